[rtl/ipv4rx_pkg.sv]
// Shared types and constants of the IPv4 receive header checker.
package ipv4rx_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [15:0] MAX_REASM_RST = 16'hFFFF;

  // Register word indexes on the configuration port.
  localparam logic REG_MAX_REASM = 1'b0;

  localparam logic [12:0] FRAG_OFF_MASK = 13'h1FFF;
  localparam int          MF_BIT        = 13;
  localparam logic [2:0]  ALIGN_MASK    = 3'h7;
  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [3:0]  IP_VERSION4   = 4'd4;
  localparam logic [3:0]  MIN_IHL       = 4'd5;

  typedef enum logic [3:0] {
    ST_WHOLE_OK     = 4'd0,
    ST_FRAG_OK      = 4'd1,
    ST_SHORT_FRAME  = 4'd2,
    ST_BAD_VERSION  = 4'd3,
    ST_SHORT_IHL    = 4'd4,
    ST_FRAME_LT_HDR = 4'd5,
    ST_BAD_CSUM     = 4'd6,
    ST_TOT_LT_HDR   = 4'd7,
    ST_FRAME_LT_TOT = 4'd8,
    ST_EMPTY_FRAG   = 4'd9,
    ST_MISALIGNED   = 4'd10,
    ST_TOO_LARGE    = 4'd11
  } status_t;

  // One parsed header, handed from the parser to the judge.
  typedef struct packed {
    logic        early;
    status_t     early_status;
    logic [15:0] csum;
    logic [15:0] total_len;
    logic [15:0] ident;
    logic [15:0] flags_frag;
    logic [7:0]  protocol;
    logic [31:0] src;
    logic [31:0] dst;
    logic [5:0]  hdr_len;
    logic [15:0] rx_len;
  } hdr_rec_t;

endpackage

[rtl/ipv4_rx_header_checker_unit.sv]
// Top level of the IPv4 receive header checker with its configuration port.
// Throughput: one frame byte per cycle, set by the single sum-and-capture step,
// while the queue has room. A result item passes the queue write, then the judge
// register, after its last header byte (or first byte, for an early reject) is taken.
// Reset (synchronous, rst_n low) empties the queue and output register, makes the
// parser ignore bytes until a first byte, and sets max_reassembly_len to 65535.
module ipv4_rx_header_checker_unit #(
  parameter int QUEUE_DEPTH = ipv4rx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_first_byte,
  input  logic [15:0]                       in_frame_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0]                        out_status,
  output logic [7:0]                        out_protocol,
  output logic [31:0]                       out_source_address,
  output logic [31:0]                       out_destination_address,
  output logic [5:0]                        out_header_length,
  output logic [15:0]                       out_payload_length,
  output logic [15:0]                       out_fragment_offset,
  output logic                              out_more_fragments,
  output logic [15:0]                       out_identification,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipv4rx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ipv4rx_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ipv4rx_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready
);
  import ipv4rx_pkg::*;

  logic [15:0] max_reasm_r;
  logic        cfg_wr;
  logic        q_full, q_not_empty, push, pop;
  hdr_rec_t    push_rec, head_rec;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_REASM);
  assign prdata = (paddr[2] == REG_MAX_REASM) ? {16'd0, max_reasm_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_reasm_r <= MAX_REASM_RST;
    end else if (cfg_wr) begin
      max_reasm_r <= pwdata[15:0];
    end
  end

  ipv4rx_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_first_byte   (in_first_byte),
    .in_frame_length (in_frame_length),
    .q_full          (q_full),
    .push            (push),
    .rec             (push_rec)
  );

  ipv4rx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head_rec  (head_rec),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ipv4rx_judge u_judge (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_not_empty             (q_not_empty),
    .head_rec                (head_rec),
    .pop                     (pop),
    .max_reasm_len           (max_reasm_r),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_status              (out_status),
    .out_protocol            (out_protocol),
    .out_source_address      (out_source_address),
    .out_destination_address (out_destination_address),
    .out_header_length       (out_header_length),
    .out_payload_length      (out_payload_length),
    .out_fragment_offset     (out_fragment_offset),
    .out_more_fragments      (out_more_fragments),
    .out_identification      (out_identification)
  );

endmodule

[rtl/ipv4rx_parser.sv]
// Front end: takes frame bytes, sums the header and captures its fields.
module ipv4rx_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_byte,
  input  logic [15:0]         in_frame_length,
  input  logic                q_full,
  output logic                push,
  output ipv4rx_pkg::hdr_rec_t rec
);
  import ipv4rx_pkg::*;

  localparam logic [5:0] IDX_MAX = 6'd63;

  logic [5:0]  idx_r, idx_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [5:0]  hb_r, hb_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] ff_r, ff_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic        given_r, given_nxt;

  logic        active;
  logic [5:0]  idx;
  logic [3:0]  ihl;
  status_t     early_st;
  logic        early_err;
  logic        last_byte;
  logic [16:0] sum17;

  assign in_ready = !q_full;
  assign active   = in_valid && in_ready && (in_first_byte || !given_r);
  assign idx      = in_first_byte ? 6'd0 : idx_r;
  assign ihl      = in_data_byte[3:0];

  always_comb begin
    // A first byte starts from a cleared header.
    flen_nxt  = in_first_byte ? in_frame_length : flen_r;
    hb_nxt    = in_first_byte ? 6'd0  : hb_r;
    sum_nxt   = in_first_byte ? 16'd0 : sum_r;
    hold_nxt  = in_first_byte ? 8'd0  : hold_r;
    tot_nxt   = in_first_byte ? 16'd0 : tot_r;
    ident_nxt = in_first_byte ? 16'd0 : ident_r;
    ff_nxt    = in_first_byte ? 16'd0 : ff_r;
    proto_nxt = in_first_byte ? 8'd0  : proto_r;
    src_nxt   = in_first_byte ? 32'd0 : src_r;
    dst_nxt   = in_first_byte ? 32'd0 : dst_r;

    early_st = ST_WHOLE_OK;
    if (flen_nxt < MIN_HDR_BYTES) begin
      early_st = ST_SHORT_FRAME;
    end else if (in_data_byte[7:4] != IP_VERSION4) begin
      early_st = ST_BAD_VERSION;
    end else if (ihl < MIN_IHL) begin
      early_st = ST_SHORT_IHL;
    end else if (flen_nxt < {10'd0, ihl, 2'b00}) begin
      early_st = ST_FRAME_LT_HDR;
    end
    early_err = (idx == 6'd0) && (early_st != ST_WHOLE_OK);

    if (idx == 6'd0) begin
      hb_nxt = {ihl, 2'b00};
    end

    case (idx)
      6'd2:    tot_nxt[15:8]   = in_data_byte;
      6'd3:    tot_nxt[7:0]    = in_data_byte;
      6'd4:    ident_nxt[15:8] = in_data_byte;
      6'd5:    ident_nxt[7:0]  = in_data_byte;
      6'd6:    ff_nxt[15:8]    = in_data_byte;
      6'd7:    ff_nxt[7:0]     = in_data_byte;
      6'd9:    proto_nxt       = in_data_byte;
      6'd12:   src_nxt[31:24]  = in_data_byte;
      6'd13:   src_nxt[23:16]  = in_data_byte;
      6'd14:   src_nxt[15:8]   = in_data_byte;
      6'd15:   src_nxt[7:0]    = in_data_byte;
      6'd16:   dst_nxt[31:24]  = in_data_byte;
      6'd17:   dst_nxt[23:16]  = in_data_byte;
      6'd18:   dst_nxt[15:8]   = in_data_byte;
      6'd19:   dst_nxt[7:0]    = in_data_byte;
      default: ;
    endcase

    // Odd bytes close a 16-bit word; the carry wraps around.
    sum17 = {1'b0, sum_nxt} + {1'b0, hold_nxt, in_data_byte};
    if (idx[0]) begin
      sum_nxt = sum17[15:0] + {15'd0, sum17[16]};
    end else begin
      hold_nxt = in_data_byte;
    end

    idx_nxt   = (idx == IDX_MAX) ? IDX_MAX : idx + 6'd1;
    last_byte = ({1'b0, idx} + 7'd1) == {1'b0, hb_nxt};

    given_nxt = given_r;
    push      = 1'b0;
    if (active) begin
      if (early_err || last_byte) begin
        given_nxt = 1'b1;
        push      = 1'b1;
      end else begin
        given_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    rec.early        = early_err;
    rec.early_status = early_st;
    rec.csum         = sum_nxt;
    rec.total_len    = tot_nxt;
    rec.ident        = ident_nxt;
    rec.flags_frag   = ff_nxt;
    rec.protocol     = proto_nxt;
    rec.src          = src_nxt;
    rec.dst          = dst_nxt;
    rec.hdr_len      = hb_nxt;
    rec.rx_len       = flen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 6'd0;
      hb_r    <= 6'd0;
      given_r <= 1'b1;
    end else begin
      given_r <= given_nxt;
      if (active && !early_err) begin
        idx_r <= idx_nxt;
        hb_r  <= hb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && !early_err) begin
      flen_r  <= flen_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      tot_r   <= tot_nxt;
      ident_r <= ident_nxt;
      ff_r    <= ff_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

endmodule

[rtl/ipv4rx_queue.sv]
// Short queue of parsed headers between the parser and the judge.
module ipv4rx_queue #(
  parameter int DEPTH = ipv4rx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ipv4rx_pkg::hdr_rec_t push_rec,
  input  logic                 pop,
  output ipv4rx_pkg::hdr_rec_t head_rec,
  output logic                 not_empty,
  output logic                 full
);
  import ipv4rx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hdr_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[rtl/ipv4rx_judge.sv]
// Back end: decides the final status of a header and holds the result item.
module ipv4rx_judge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  ipv4rx_pkg::hdr_rec_t head_rec,
  output logic                 pop,
  input  logic [15:0]          max_reasm_len,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_status,
  output logic [7:0]           out_protocol,
  output logic [31:0]          out_source_address,
  output logic [31:0]          out_destination_address,
  output logic [5:0]           out_header_length,
  output logic [15:0]          out_payload_length,
  output logic [15:0]          out_fragment_offset,
  output logic                 out_more_fragments,
  output logic [15:0]          out_identification
);
  import ipv4rx_pkg::*;

  logic        valid_r;
  logic [3:0]  status_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r, dst_r;
  logic [5:0]  hlen_r;
  logic [15:0] pay_r, off_r, ident_r;
  logic        mf_r;

  logic        tot_lt_hdr;
  logic [15:0] pay_raw, pay, off;
  logic        more;
  logic [16:0] reach;
  status_t     st;

  assign pop = q_not_empty && (!valid_r || out_ready);

  always_comb begin
    tot_lt_hdr = head_rec.total_len < {10'd0, head_rec.hdr_len};
    pay_raw    = head_rec.total_len - {10'd0, head_rec.hdr_len};
    pay        = tot_lt_hdr ? 16'd0 : pay_raw;
    off        = {head_rec.flags_frag[12:0] & FRAG_OFF_MASK, 3'b000};
    more       = head_rec.flags_frag[MF_BIT];
    reach      = {1'b0, off} + {1'b0, pay};

    if (head_rec.early) begin
      st = head_rec.early_status;
    end else if (head_rec.csum != 16'hFFFF) begin
      st = ST_BAD_CSUM;
    end else if (tot_lt_hdr) begin
      st = ST_TOT_LT_HDR;
    end else if (head_rec.rx_len < head_rec.total_len) begin
      st = ST_FRAME_LT_TOT;
    end else if ((off != 16'd0) || more) begin
      if (pay == 16'd0) begin
        st = ST_EMPTY_FRAG;
      end else if (more && ((pay[2:0] & ALIGN_MASK) != 3'd0)) begin
        st = ST_MISALIGNED;
      end else if (reach > {1'b0, max_reasm_len}) begin
        st = ST_TOO_LARGE;
      end else begin
        st = ST_FRAG_OK;
      end
    end else begin
      st = ST_WHOLE_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Early rejects carry only a status; every other field reads zero.
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= st;
      proto_r  <= head_rec.early ? 8'd0  : head_rec.protocol;
      src_r    <= head_rec.early ? 32'd0 : head_rec.src;
      dst_r    <= head_rec.early ? 32'd0 : head_rec.dst;
      hlen_r   <= head_rec.early ? 6'd0  : head_rec.hdr_len;
      pay_r    <= head_rec.early ? 16'd0 : pay;
      off_r    <= head_rec.early ? 16'd0 : off;
      mf_r     <= head_rec.early ? 1'b0  : more;
      ident_r  <= head_rec.early ? 16'd0 : head_rec.ident;
    end
  end

  assign out_valid               = valid_r;
  assign out_status              = status_r;
  assign out_protocol            = proto_r;
  assign out_source_address      = src_r;
  assign out_destination_address = dst_r;
  assign out_header_length       = hlen_r;
  assign out_payload_length      = pay_r;
  assign out_fragment_offset     = off_r;
  assign out_more_fragments      = mf_r;
  assign out_identification      = ident_r;

endmodule

[rtl/ipv4rx_checker.sv]
// Port-level assertions for the IPv4 receive header checker, bound to the top level.
module ipv4rx_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [3:0]                        out_status,
  input logic [5:0]                        out_header_length,
  input logic [15:0]                       out_payload_length,
  input logic [15:0]                       out_fragment_offset,
  input logic                              out_more_fragments,
  input logic                              pready
);
  import ipv4rx_pkg::*;

  // A waiting result item keeps its status until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid right after reset");

  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SHORT_FRAME || out_status == ST_BAD_VERSION ||
                  out_status == ST_SHORT_IHL || out_status == ST_FRAME_LT_HDR)
    |-> out_header_length == 6'd0 && out_payload_length == 16'd0)
    else $error("early reject carries header fields");

  a_full_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_WHOLE_OK || out_status == ST_FRAG_OK ||
                  out_status == ST_BAD_CSUM)
    |-> out_header_length >= 6'd20)
    else $error("checked header shorter than minimum");

  a_frag_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FRAG_OK
    |-> (out_more_fragments || out_fragment_offset != 16'd0) && pready)
    else $error("fragment status on a whole packet");

endmodule

bind ipv4_rx_header_checker_unit ipv4rx_checker u_ipv4rx_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_header_length   (out_header_length),
  .out_payload_length  (out_payload_length),
  .out_fragment_offset (out_fragment_offset),
  .out_more_fragments  (out_more_fragments),
  .pready              (pready)
);
